@@ src/mscsr_pkg.sv @@
// Types, CSR addresses, WARL masks and fixed values for the machine/supervisor CSR file.
package mscsr_pkg;

    typedef logic [11:0] csr_addr_t;
    typedef logic [31:0] csr_word_t;

    // Access kind
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Machine-level addresses
    localparam csr_addr_t A_MVENDORID = 12'hF11;
    localparam csr_addr_t A_MARCHID   = 12'hF12;
    localparam csr_addr_t A_MIMPID    = 12'hF13;
    localparam csr_addr_t A_MHARTID   = 12'hF14;
    localparam csr_addr_t A_MSTATUS   = 12'h300;
    localparam csr_addr_t A_MISA      = 12'h301;
    localparam csr_addr_t A_MEDELEG   = 12'h302;
    localparam csr_addr_t A_MIDELEG   = 12'h303;
    localparam csr_addr_t A_MIE       = 12'h304;
    localparam csr_addr_t A_MTVEC     = 12'h305;
    localparam csr_addr_t A_MSCRATCH  = 12'h340;
    localparam csr_addr_t A_MEPC      = 12'h341;
    localparam csr_addr_t A_MCAUSE    = 12'h342;
    localparam csr_addr_t A_MTVAL     = 12'h343;
    localparam csr_addr_t A_MIP       = 12'h344;

    // Supervisor-level addresses
    localparam csr_addr_t A_SSTATUS   = 12'h100;
    localparam csr_addr_t A_SIE       = 12'h104;
    localparam csr_addr_t A_STVEC     = 12'h105;
    localparam csr_addr_t A_SSCRATCH  = 12'h140;
    localparam csr_addr_t A_SEPC      = 12'h141;
    localparam csr_addr_t A_SCAUSE    = 12'h142;
    localparam csr_addr_t A_STVAL     = 12'h143;
    localparam csr_addr_t A_SIP       = 12'h144;
    localparam csr_addr_t A_SATP      = 12'h180;

    // Fixed values (MXL = 32 bits, extension I)
    localparam csr_word_t MISA_VALUE   = 32'h4000_0100;
    localparam csr_word_t MIMPID_VALUE = 32'h0000_0001;

    // WARL masks
    localparam csr_word_t MEDELEG_MASK = 32'h0000_B3FF;
    localparam csr_word_t MIDELEG_MASK = 32'h0000_0AAA;
    localparam csr_word_t MIP_MASK     = 32'h0000_0008;
    localparam csr_word_t SIP_MASK     = 32'h0000_0002;
    localparam csr_word_t SIE_MASK     = 32'h0000_0222;
    localparam csr_word_t SSTATUS_MASK = 32'h0000_0122;

    typedef struct packed {
        csr_word_t mach_status;
        csr_word_t exc_delegation;
        csr_word_t int_delegation;
        csr_word_t mach_int_enable;
        csr_word_t mach_trap_vector;
        csr_word_t mach_scratch;
        csr_word_t mach_exc_pc;
        csr_word_t mach_cause;
        csr_word_t mach_trap_value;
        csr_word_t mach_int_pending;
        csr_word_t sup_status;
        csr_word_t sup_int_enable;
        csr_word_t sup_trap_vector;
        csr_word_t sup_scratch;
        csr_word_t sup_exc_pc;
        csr_word_t sup_cause;
        csr_word_t sup_trap_value;
        csr_word_t sup_int_pending;
        csr_word_t addr_translation;
    } csr_state_t;

    function automatic csr_word_t merge(csr_word_t old_val, csr_word_t new_val,
                                        csr_word_t mask);
        return (old_val & ~mask) | (new_val & mask);
    endfunction

endpackage

@@ src/machine_supervisor_csr_file_top.sv @@
// Machine and supervisor CSR file, RV32, standard privileged numbering.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one access word: s_kind selects
//   read or write, s_csr_addr the CSR, s_write_data the value for a write.
//   Result channel (m_valid/m_ready) returns one word per access: the CSR
//   value for a read, zero for a write or for an unimplemented address.
//   Address decode, WARL masking and the register update happen in the cycle
//   the access is accepted; the result sits in the output register from the
//   next cycle, and throughput is one access per cycle while m_ready holds.
//   A read sees every write accepted before it.
//   The output register doubles as the stage boundary: s_ready stays high
//   while the output is empty or being taken this cycle. When the receiver
//   stalls, the held result stays put and s_ready stays low, so every new
//   access waits until m_ready returns, which sets the rate under backpressure.
//   Reset (aresetn low, synchronous) clears every CSR to zero and empties the
//   output register.
module machine_supervisor_csr_file_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  mscsr_pkg::csr_addr_t  s_csr_addr,
    input  mscsr_pkg::csr_word_t  s_write_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mscsr_pkg::csr_word_t  m_read_data
);
    import mscsr_pkg::*;

    csr_state_t state_reg, state_next;
    logic       m_valid_reg;
    csr_word_t  m_read_data_reg;
    csr_word_t  read_value;
    logic       s_accept;

    // Output register is free when empty or drained this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Read decode; ID registers other than mimpid read as zero
    always_comb begin
        case (s_csr_addr)
            A_MVENDORID, A_MARCHID, A_MHARTID: read_value = '0;
            A_MIMPID:   read_value = MIMPID_VALUE;
            A_MISA:     read_value = MISA_VALUE;
            A_MSTATUS:  read_value = state_reg.mach_status;
            A_MEDELEG:  read_value = state_reg.exc_delegation;
            A_MIDELEG:  read_value = state_reg.int_delegation;
            A_MIE:      read_value = state_reg.mach_int_enable;
            A_MTVEC:    read_value = state_reg.mach_trap_vector;
            A_MSCRATCH: read_value = state_reg.mach_scratch;
            A_MEPC:     read_value = state_reg.mach_exc_pc;
            A_MCAUSE:   read_value = state_reg.mach_cause;
            A_MTVAL:    read_value = state_reg.mach_trap_value;
            A_MIP:      read_value = state_reg.mach_int_pending;
            A_SSTATUS:  read_value = state_reg.sup_status;
            A_SIE:      read_value = state_reg.sup_int_enable;
            A_STVEC:    read_value = state_reg.sup_trap_vector;
            A_SSCRATCH: read_value = state_reg.sup_scratch;
            A_SEPC:     read_value = state_reg.sup_exc_pc;
            A_SCAUSE:   read_value = state_reg.sup_cause;
            A_STVAL:    read_value = state_reg.sup_trap_value;
            A_SIP:      read_value = state_reg.sup_int_pending;
            A_SATP:     read_value = state_reg.addr_translation;
            default:    read_value = '0;
        endcase
    end

    // Write decode with WARL masks; read-only and unknown addresses drop the write
    always_comb begin
        state_next = state_reg;
        if (s_accept && s_kind == KIND_WRITE) begin
            case (s_csr_addr)
                A_MSTATUS:  state_next.mach_status      = s_write_data;
                A_MEDELEG:  state_next.exc_delegation   = s_write_data & MEDELEG_MASK;
                A_MIDELEG:  state_next.int_delegation   = s_write_data & MIDELEG_MASK;
                A_MIE:      state_next.mach_int_enable  = s_write_data;
                A_MTVEC:    state_next.mach_trap_vector = s_write_data;
                A_MSCRATCH: state_next.mach_scratch     = s_write_data;
                A_MEPC:     state_next.mach_exc_pc      = s_write_data;
                A_MCAUSE:   state_next.mach_cause       = s_write_data;
                A_MTVAL:    state_next.mach_trap_value  = s_write_data;
                A_MIP: begin
                    state_next.mach_int_pending =
                        merge(state_reg.mach_int_pending, s_write_data, MIP_MASK);
                end
                A_SSTATUS: begin
                    // SIE, SPIE and SPP land in both status registers
                    state_next.sup_status =
                        merge(state_reg.sup_status, s_write_data, SSTATUS_MASK);
                    state_next.mach_status =
                        merge(state_reg.mach_status, s_write_data, SSTATUS_MASK);
                end
                A_SIE: begin
                    state_next.sup_int_enable =
                        merge(state_reg.sup_int_enable, s_write_data, SIE_MASK);
                end
                A_STVEC:    state_next.sup_trap_vector  = s_write_data;
                A_SSCRATCH: state_next.sup_scratch      = s_write_data;
                A_SEPC:     state_next.sup_exc_pc       = s_write_data;
                A_SCAUSE:   state_next.sup_cause        = s_write_data;
                A_STVAL:    state_next.sup_trap_value   = s_write_data;
                A_SIP: begin
                    state_next.sup_int_pending =
                        merge(state_reg.sup_int_pending, s_write_data, SIP_MASK);
                end
                A_SATP:     state_next.addr_translation = s_write_data;
                default:    state_next = state_reg;
            endcase
        end
    end

    // CSR state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register: valid flag under reset, data loaded on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_read_data_reg <= (s_kind == KIND_WRITE) ? '0 : read_value;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;

    // A write always answers with zero
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_WRITE) |=> (m_valid && m_read_data == '0))
        else $error("write access returned non-zero word");

    // The delegation registers never hold bits outside their WARL masks
    a_warl_masks: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg.exc_delegation & ~MEDELEG_MASK) == '0) &&
        ((state_reg.int_delegation & ~MIDELEG_MASK) == '0))
        else $error("delegation register holds bits outside its mask");

    // sstatus only ever takes SIE, SPIE and SPP
    a_sstatus_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.sup_status & ~SSTATUS_MASK) == '0)
        else $error("sstatus holds bits outside its mask");

    // misa reads back its fixed value
    a_misa_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_READ && s_csr_addr == A_MISA)
        |=> (m_read_data == MISA_VALUE))
        else $error("misa read returned wrong value");

    // A write to sstatus mirrors its field into mstatus
    a_sstatus_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_WRITE && s_csr_addr == A_SSTATUS)
        |=> ((state_reg.mach_status & SSTATUS_MASK) ==
             (state_reg.sup_status & SSTATUS_MASK)))
        else $error("sstatus write not mirrored into mstatus");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the machine/supervisor CSR file: shadow CSR model and checks.
module testbench;
    import mscsr_pkg::*;

    // One access word as the sender queues it. hold_for_drain makes the
    // sender wait until every earlier result has come back before offering it.
    typedef struct {
        logic      kind;
        csr_addr_t addr;
        csr_word_t data;
        bit        hold_for_drain;
    } csr_access_t;

    // Every implemented address, read-only ones included.
    localparam csr_addr_t IMPL_CSRS [24] = '{
        A_MVENDORID, A_MARCHID, A_MIMPID, A_MHARTID,
        A_MSTATUS, A_MISA, A_MEDELEG, A_MIDELEG, A_MIE, A_MTVEC,
        A_MSCRATCH, A_MEPC, A_MCAUSE, A_MTVAL, A_MIP,
        A_SSTATUS, A_SIE, A_STVEC, A_SSCRATCH, A_SEPC, A_SCAUSE, A_STVAL,
        A_SIP, A_SATP
    };

    localparam int N_RANDOM    = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Clock and reset. aresetn is synchronous; held low at start, then released.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #2 aclk = ~aclk;

    // DUT inputs start at known values.
    logic      s_valid      = 1'b0;
    logic      s_kind       = KIND_READ;
    csr_addr_t s_csr_addr   = '0;
    csr_word_t s_write_data = '0;
    logic      m_ready      = 1'b0;
    logic      s_ready;
    logic      m_valid;
    csr_word_t m_read_data;

    machine_supervisor_csr_file_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_csr_addr   (s_csr_addr),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data)
    );

    // Shadow copy of every CSR, cleared like the block after reset.
    csr_word_t mstatus_r  = '0;
    csr_word_t medeleg_r  = '0;
    csr_word_t mideleg_r  = '0;
    csr_word_t mie_r      = '0;
    csr_word_t mtvec_r    = '0;
    csr_word_t mscratch_r = '0;
    csr_word_t mepc_r     = '0;
    csr_word_t mcause_r   = '0;
    csr_word_t mtval_r    = '0;
    csr_word_t mip_r      = '0;
    csr_word_t sstatus_r  = '0;
    csr_word_t sie_r      = '0;
    csr_word_t stvec_r    = '0;
    csr_word_t sscratch_r = '0;
    csr_word_t sepc_r     = '0;
    csr_word_t scause_r   = '0;
    csr_word_t stval_r    = '0;
    csr_word_t sip_r      = '0;
    csr_word_t satp_r     = '0;

    csr_access_t pending_accesses [$];   // words still to be offered
    csr_word_t   expected_rdata [$];     // predicted results, oldest first

    // Word counts, both updated by NBA so either side reads a settled value.
    int unsigned words_sent  = 0;
    int unsigned words_recvd = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // Sender burst/gap state, receiver stall state.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned rx_mode    = 0;
    int unsigned rx_phase   = 0;
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;

    // Applies one access to the shadow CSRs; returns the word the block
    // should hand back: the CSR value on a read, zero on a write.
    function automatic csr_word_t apply_csr_access(logic kind, csr_addr_t a,
                                                   csr_word_t d);
        csr_word_t rd;
        rd = '0;
        if (kind == KIND_WRITE) begin
            case (a)
                A_MSTATUS:  mstatus_r  = d;
                A_MEDELEG:  medeleg_r  = d & MEDELEG_MASK;
                A_MIDELEG:  mideleg_r  = d & MIDELEG_MASK;
                A_MIE:      mie_r      = d;
                A_MTVEC:    mtvec_r    = d;
                A_MSCRATCH: mscratch_r = d;
                A_MEPC:     mepc_r     = d;
                A_MCAUSE:   mcause_r   = d;
                A_MTVAL:    mtval_r    = d;
                A_MIP:      mip_r      = (mip_r & ~MIP_MASK) | (d & MIP_MASK);
                A_SSTATUS: begin
                    // sstatus write lands in both copies, through the same mask
                    sstatus_r = (sstatus_r & ~SSTATUS_MASK) | (d & SSTATUS_MASK);
                    mstatus_r = (mstatus_r & ~SSTATUS_MASK) | (d & SSTATUS_MASK);
                end
                A_SIE:      sie_r      = (sie_r & ~SIE_MASK) | (d & SIE_MASK);
                A_STVEC:    stvec_r    = d;
                A_SSCRATCH: sscratch_r = d;
                A_SEPC:     sepc_r     = d;
                A_SCAUSE:   scause_r   = d;
                A_STVAL:    stval_r    = d;
                A_SIP:      sip_r      = (sip_r & ~SIP_MASK) | (d & SIP_MASK);
                A_SATP:     satp_r     = d;
                default: ;  // read-only or unimplemented: dropped
            endcase
        end else begin
            case (a)
                A_MIMPID:   rd = MIMPID_VALUE;
                A_MISA:     rd = MISA_VALUE;
                A_MSTATUS:  rd = mstatus_r;
                A_MEDELEG:  rd = medeleg_r;
                A_MIDELEG:  rd = mideleg_r;
                A_MIE:      rd = mie_r;
                A_MTVEC:    rd = mtvec_r;
                A_MSCRATCH: rd = mscratch_r;
                A_MEPC:     rd = mepc_r;
                A_MCAUSE:   rd = mcause_r;
                A_MTVAL:    rd = mtval_r;
                A_MIP:      rd = mip_r;
                A_SSTATUS:  rd = sstatus_r;
                A_SIE:      rd = sie_r;
                A_STVEC:    rd = stvec_r;
                A_SSCRATCH: rd = sscratch_r;
                A_SEPC:     rd = sepc_r;
                A_SCAUSE:   rd = scause_r;
                A_STVAL:    rd = stval_r;
                A_SIP:      rd = sip_r;
                A_SATP:     rd = satp_r;
                default:    rd = '0;  // vendor/arch/hart IDs and unknown
            endcase
        end
        return rd;
    endfunction

    task automatic queue_access(logic kind, csr_addr_t a, csr_word_t d);
        csr_access_t acc;
        acc.kind           = kind;
        acc.addr           = a;
        acc.data           = d;
        acc.hold_for_drain = 1'b0;
        pending_accesses.push_back(acc);
    endtask

    task automatic note_failure(string what, csr_word_t want, csr_word_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0d] %s: expected %08h, got %08h", cycle_count, what, want, got);
    endtask

    // Write data: mostly random, with all-ones, zero and walking bits mixed in
    // so the WARL masks see their edges.
    function automatic csr_word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return csr_word_t'(1) << $urandom_range(0, 31);
            3:       return ~(csr_word_t'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Sender. A new word is loaded when the slot is free after this edge,
    // i.e. nothing was offered or the offered word was just taken. s_valid
    // gets exactly one NBA per edge, so a back-to-back word never drops valid.
    always @(posedge aclk) begin : sender
        logic        next_valid;
        csr_access_t acc;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rdata.push_back(apply_csr_access(s_kind, s_csr_addr,
                                                          s_write_data));
                words_sent <= words_sent + 1;
            end
            next_valid = s_valid && !s_ready;
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_accesses.size() != 0 &&
                             !(pending_accesses[0].hold_for_drain &&
                               (s_valid || words_sent != words_recvd))) begin
                    // A drain-marked word waits until nothing is in flight.
                    acc = pending_accesses.pop_front();
                    s_kind       <= acc.kind;
                    s_csr_addr   <= acc.addr;
                    s_write_data <= acc.data;
                    next_valid = 1'b1;
                    if (burst_left != 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        // Now and then a long burst with no gap at all.
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = 64;
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // Receiver. Runs in phases: always ready, coin-flip, or mostly stalled.
    // Twice during the run, after 400 and 1200 results, it holds off while the sender keeps
    // going, so the output register fills and s_ready drops.
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if ((holds_done == 0 && words_recvd >= 400) ||
                     (holds_done == 1 && words_recvd >= 1200)) begin
            holds_done++;
            hold_left = 199;
            m_ready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_mode  = $urandom_range(0, 2);
                rx_phase = $urandom_range(20, 150);
            end
            rx_phase--;
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Result checker: each word taken is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        csr_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_recvd <= words_recvd + 1;
            if (expected_rdata.size() == 0) begin
                note_failure("result with nothing outstanding", '0, m_read_data);
            end else begin
                want = expected_rdata.pop_front();
                if (m_read_data !== want)
                    note_failure("read_data mismatch", want, m_read_data);
            end
        end
    end

    // Watchdog, far above the slowest legal run.
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        csr_addr_t a;
        int unsigned n;
        int unsigned r;

        // Directed: ID values and unknown addresses straight out of reset.
        queue_access(KIND_READ,  A_MIMPID,    '0);
        queue_access(KIND_READ,  A_MISA,      '0);
        queue_access(KIND_READ,  A_MVENDORID, '0);
        queue_access(KIND_READ,  12'h000,     '0);
        queue_access(KIND_READ,  12'hFFF,     '1);
        // All-ones through every WARL mask, plus writes that must be dropped.
        queue_access(KIND_WRITE, A_MEDELEG,   '1);
        queue_access(KIND_WRITE, A_MIDELEG,   '1);
        queue_access(KIND_WRITE, A_MIP,       '1);
        queue_access(KIND_WRITE, A_SIP,       '1);
        queue_access(KIND_WRITE, A_SIE,       '1);
        queue_access(KIND_WRITE, A_SSTATUS,   '1);
        queue_access(KIND_WRITE, A_MISA,      '0);
        queue_access(KIND_WRITE, A_MIMPID,    '0);
        queue_access(KIND_WRITE, 12'hFFF,     '1);
        queue_access(KIND_READ,  A_MEDELEG,   '0);
        queue_access(KIND_READ,  A_MIDELEG,   '0);
        queue_access(KIND_READ,  A_MIP,       '0);
        queue_access(KIND_READ,  A_SIP,       '0);
        queue_access(KIND_READ,  A_SIE,       '0);
        queue_access(KIND_READ,  A_SSTATUS,   '0);
        queue_access(KIND_READ,  A_MSTATUS,   '0);
        queue_access(KIND_READ,  A_MISA,      '0);
        queue_access(KIND_READ,  A_MIMPID,    '0);
        // Full-width mstatus, then a clearing sstatus write touches only its bits.
        queue_access(KIND_WRITE, A_MSTATUS,   '1);
        queue_access(KIND_WRITE, A_SSTATUS,   '0);
        queue_access(KIND_READ,  A_MSTATUS,   '0);

        // Random part. Most of it is write-then-read on an implemented CSR so
        // the masks and the sstatus/mstatus coupling get exercised; the rest
        // is lone reads and fully random words at any address.
        n = 0;
        while (n < N_RANDOM) begin
            r = $urandom_range(0, 9);
            a = IMPL_CSRS[5'($urandom_range(0, 23))];
            if (r < 6) begin
                queue_access(KIND_WRITE, a, pick_word());
                if (a == A_SSTATUS && $urandom_range(0, 1) == 1)
                    queue_access(KIND_READ, A_MSTATUS, $urandom);
                else
                    queue_access(KIND_READ, a, $urandom);
                n += 2;
            end else if (r < 8) begin
                queue_access(KIND_READ, a, $urandom);
                n++;
            end else begin
                queue_access(1'($urandom_range(0, 1)), csr_addr_t'($urandom), pick_word());
                n++;
            end
        end

        // Sender pauses here until the block has emptied out.
        pending_accesses[800].hold_for_drain = 1'b1;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_accesses.size() != 0 || s_valid || words_recvd != words_sent)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (expected_rdata.size() != 0)
            note_failure("predictions left over", csr_word_t'(expected_rdata.size()), '0);

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
